@@ sv/jcme_pkg.sv @@
// shared types, codes and text tables of the chat message encoder
`timescale 1ns / 1ps
`default_nettype none

package jcme_pkg;

  // input item modes
  localparam logic [1:0] MODE_SYS = 2'd0;
  localparam logic [1:0] MODE_USR = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  // configuration register indexes
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_COUNT_ONLY = 1'b1;

  // chunk slots, in emission order, as bit positions of a chunk set
  localparam int unsigned NUM_SLOTS  = 8;
  localparam logic [2:0] SLOT_OPEN    = 3'd0;
  localparam logic [2:0] SLOT_SYS_QO  = 3'd1;
  localparam logic [2:0] SLOT_SYS_QC  = 3'd2;
  localparam logic [2:0] SLOT_MID     = 3'd3;
  localparam logic [2:0] SLOT_USR_QO  = 3'd4;
  localparam logic [2:0] SLOT_CONTENT = 3'd5;
  localparam logic [2:0] SLOT_USR_QC  = 3'd6;
  localparam logic [2:0] SLOT_CLOSE   = 3'd7;

  // fixed texts
  localparam int unsigned OPEN_LEN  = 28;
  localparam int unsigned MID_LEN   = 27;
  localparam int unsigned CLOSE_LEN = 2;
  localparam logic [8*OPEN_LEN-1:0]  OPEN_TXT  = "[{\"role\":\"system\",\"content\":";
  localparam logic [8*MID_LEN-1:0]   MID_TXT   = "},{\"role\":\"user\",\"content\":";
  localparam logic [8*CLOSE_LEN-1:0] CLOSE_TXT = "}]";
  localparam logic [8*16-1:0]        HEX_TXT   = "0123456789abcdef";

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CTRL_TOP = 8'h20;

  // escape form of one content byte
  typedef enum logic [1:0] {
    ESC_PLAIN = 2'd0,
    ESC_SHORT = 2'd1,
    ESC_UNI   = 2'd2
  } esc_kind_e;

  // classified item passed from front to back
  typedef struct packed {
    logic [NUM_SLOTS-1:0] chunks;
    logic [7:0]           ch;
    esc_kind_e            kind;
    logic [7:0]           esc2;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] position;
    logic        stored;
    logic        last;
    logic        finished;
    logic        success;
    logic [15:0] total_length;
  } res_t;

  // number of bytes in a chunk
  function automatic logic [4:0] chunk_len(input logic [2:0] slot, input esc_kind_e kind);
    logic [4:0] n;
    n = 5'd1;
    case (slot)
      SLOT_OPEN:    n = 5'(OPEN_LEN);
      SLOT_MID:     n = 5'(MID_LEN);
      SLOT_CLOSE:   n = 5'(CLOSE_LEN);
      SLOT_CONTENT: begin
        case (kind)
          ESC_SHORT: n = 5'd2;
          ESC_UNI:   n = 5'd6;
          default:   n = 5'd1;
        endcase
      end
      default:      n = 5'd1;
    endcase
    return n;
  endfunction

  // lower-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return HEX_TXT[8*(15 - int'(v)) +: 8];
  endfunction

  // byte of an escaped content chunk
  function automatic logic [7:0] content_byte(input cmd_t c, input logic [4:0] idx);
    logic [7:0] b;
    b = c.ch;
    case (c.kind)
      ESC_SHORT: b = (idx == 5'd0) ? CH_BSL : c.esc2;
      ESC_UNI: begin
        case (idx)
          5'd0:    b = CH_BSL;
          5'd1:    b = CH_U;
          5'd2:    b = CH_ZERO;
          5'd3:    b = CH_ZERO;
          5'd4:    b = hex_digit(c.ch[7:4]);
          default: b = hex_digit(c.ch[3:0]);
        endcase
      end
      default:   b = c.ch;
    endcase
    return b;
  endfunction

  // byte idx of the chunk in slot
  function automatic logic [7:0] chunk_byte(input logic [2:0] slot, input cmd_t c,
                                            input logic [4:0] idx);
    logic [7:0] b;
    b = CH_QUOTE;
    case (slot)
      SLOT_OPEN: begin
        if (idx < 5'(OPEN_LEN)) b = OPEN_TXT[8*(OPEN_LEN - 1 - int'(idx)) +: 8];
      end
      SLOT_MID: begin
        if (idx < 5'(MID_LEN)) b = MID_TXT[8*(MID_LEN - 1 - int'(idx)) +: 8];
      end
      SLOT_CLOSE:   b = idx[0] ? CLOSE_TXT[7:0] : CLOSE_TXT[15:8];
      SLOT_CONTENT: b = content_byte(c, idx);
      default:      b = CH_QUOTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/jcme_front.sv @@
// front end: takes items, tracks the message phase and classifies escapes
`timescale 1ns / 1ps
`default_nettype none

module jcme_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       mode_i,
  input  wire logic [7:0]       data_byte_i,
  output logic                  cmd_push_o,
  output jcme_pkg::cmd_t        cmd_o,
  input  wire logic             cmd_full_i
);

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_SYS  = 3'b010,
    PH_USR  = 3'b100
  } phase_e;

  phase_e phase_q, phase_d;
  logic   accept;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  always_comb begin
    // escape classification of the content byte
    cmd_o.ch   = data_byte_i;
    cmd_o.kind = jcme_pkg::ESC_SHORT;
    cmd_o.esc2 = data_byte_i;
    case (data_byte_i)
      jcme_pkg::CH_QUOTE, jcme_pkg::CH_BSL: cmd_o.esc2 = data_byte_i;
      8'h08:   cmd_o.esc2 = "b";
      8'h0c:   cmd_o.esc2 = "f";
      8'h0a:   cmd_o.esc2 = "n";
      8'h0d:   cmd_o.esc2 = "r";
      8'h09:   cmd_o.esc2 = "t";
      default: begin
        if (data_byte_i < jcme_pkg::CTRL_TOP) cmd_o.kind = jcme_pkg::ESC_UNI;
        else cmd_o.kind = jcme_pkg::ESC_PLAIN;
      end
    endcase

    // chunk set and next phase
    phase_d   = phase_q;
    cmd_o.chunks = '0;
    cmd_push_o   = 1'b0;
    if (mode_i != 2'd3) begin
      cmd_push_o = accept;
      // bring the message forward to the user string when needed
      unique case (phase_q)
        PH_NONE: begin
          cmd_o.chunks[jcme_pkg::SLOT_OPEN]   = 1'b1;
          cmd_o.chunks[jcme_pkg::SLOT_SYS_QO] = 1'b1;
          if (mode_i != jcme_pkg::MODE_SYS) begin
            cmd_o.chunks[jcme_pkg::SLOT_SYS_QC] = 1'b1;
            cmd_o.chunks[jcme_pkg::SLOT_MID]    = 1'b1;
            cmd_o.chunks[jcme_pkg::SLOT_USR_QO] = 1'b1;
          end
        end
        PH_SYS: begin
          if (mode_i != jcme_pkg::MODE_SYS) begin
            cmd_o.chunks[jcme_pkg::SLOT_SYS_QC] = 1'b1;
            cmd_o.chunks[jcme_pkg::SLOT_MID]    = 1'b1;
            cmd_o.chunks[jcme_pkg::SLOT_USR_QO] = 1'b1;
          end
        end
        PH_USR: ;
        default: ;
      endcase
      if (mode_i == jcme_pkg::MODE_END) begin
        cmd_o.chunks[jcme_pkg::SLOT_USR_QC] = 1'b1;
        cmd_o.chunks[jcme_pkg::SLOT_CLOSE]  = 1'b1;
        phase_d = PH_NONE;
      end else begin
        cmd_o.chunks[jcme_pkg::SLOT_CONTENT] = 1'b1;
        if (mode_i == jcme_pkg::MODE_USR || phase_q == PH_USR) phase_d = PH_USR;
        else phase_d = PH_SYS;
      end
    end
  end

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/jcme_cmd_queue.sv @@
// two-entry queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module jcme_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  jcme_pkg::cmd_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output jcme_pkg::cmd_t      data_o
);

  jcme_pkg::cmd_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop) rptr_q <= !rptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

@@ sv/jcme_back.sv @@
// back end: walks the chunks of an item, one byte a cycle while the output queue has room, with fit check
`timescale 1ns / 1ps
`default_nettype none

module jcme_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [15:0]    capacity_i,
  input  wire logic           count_only_i,
  input  wire logic           cmd_valid_i,
  input  jcme_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_empty_o,
  input  wire logic           res_pop_i,
  output jcme_pkg::res_t      res_o
);

  localparam int unsigned W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;
  localparam logic [W-1:0] LIMIT_W = {{(W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
  localparam logic [W-1:0] MAX16_W = {{(W-16){1'b0}}, 16'hffff};

  logic [jcme_pkg::NUM_SLOTS-1:0] done_q, remain, rest;
  logic [4:0]             idx_q, n;
  logic [2:0]             slot;
  logic [LENGTH_BITS-1:0] len_q, len_new, pos_q, len_eff, pos_cur;
  logic                   fits_q, fits_now, fits_eff;
  logic                   nov_q, nov_new, nov_eff;
  logic                   first, chunk_end, item_end, emit, out_ready, fin;
  logic [W-1:0]           len_w, sum_w, cap_w, eff_w, pos_w;
  logic                   over_limit;
  jcme_pkg::res_t         res;

  // output queue
  jcme_pkg::res_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  // pick the next chunk of the item
  assign remain = cmd_i.chunks & ~done_q;
  always_comb begin
    slot = '0;
    for (int i = jcme_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (remain[i]) slot = 3'(i);
    end
  end
  always_comb begin
    rest = remain;
    rest[slot] = 1'b0;
  end

  assign n         = jcme_pkg::chunk_len(slot, cmd_i.kind);
  assign first     = (idx_q == 5'd0);
  assign chunk_end = (idx_q == n - 5'd1);
  assign item_end  = chunk_end && (rest == '0);
  assign fin       = item_end && cmd_i.chunks[jcme_pkg::SLOT_CLOSE];

  // chunk fit check against capacity and length limit
  assign len_w      = {{(W-LENGTH_BITS){1'b0}}, len_q};
  assign sum_w      = len_w + W'(n);
  assign cap_w      = {{(W-16){1'b0}}, capacity_i};
  assign over_limit = (sum_w > LIMIT_W);
  assign fits_now   = !count_only_i && (sum_w <= cap_w) && !over_limit;

  always_comb begin
    if (count_only_i) begin
      len_new = over_limit ? {LENGTH_BITS{1'b1}} : sum_w[LENGTH_BITS-1:0];
      nov_new = nov_q;
    end else begin
      len_new = fits_now ? sum_w[LENGTH_BITS-1:0] : len_q;
      nov_new = nov_q && fits_now;
    end
  end

  // values seen by the current byte
  assign len_eff  = first ? len_new : len_q;
  assign fits_eff = first ? fits_now : fits_q;
  assign nov_eff  = first ? nov_new : nov_q;
  assign pos_cur  = first ? len_q : pos_q;
  assign eff_w    = {{(W-LENGTH_BITS){1'b0}}, len_eff};
  assign pos_w    = {{(W-LENGTH_BITS){1'b0}}, pos_cur};

  // result item
  always_comb begin
    res.out_byte     = jcme_pkg::chunk_byte(slot, cmd_i, idx_q);
    res.position     = fits_eff ? pos_w[15:0] : 16'd0;
    res.stored       = fits_eff;
    res.last         = item_end;
    res.finished     = fin;
    res.success      = fin && nov_eff && (count_only_i || eff_w == cap_w);
    res.total_length = (eff_w > MAX16_W) ? 16'hffff : eff_w[15:0];
  end

  assign out_ready = (count_q != 2'd2) || res_pop_i;
  assign emit      = cmd_valid_i && out_ready;
  assign cmd_pop_o = emit && item_end;

  // chunk walk and length state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      idx_q  <= 5'd0;
      len_q  <= '0;
      nov_q  <= 1'b1;
      fits_q <= 1'b0;
      pos_q  <= '0;
    end else if (emit) begin
      if (first) begin
        len_q  <= len_new;
        nov_q  <= nov_new;
        fits_q <= fits_now;
        pos_q  <= len_q + 1'b1;
      end else begin
        pos_q  <= pos_q + 1'b1;
      end
      if (chunk_end) begin
        idx_q  <= 5'd0;
        done_q <= item_end ? '0 : (done_q | (remain & ~rest));
      end else begin
        idx_q  <= idx_q + 5'd1;
      end
      // a finished message starts the next one from scratch
      if (fin) begin
        len_q <= '0;
        nov_q <= 1'b1;
      end
    end
  end

  // output queue storage
  assign res_empty_o = (count_q == 2'd0);
  assign do_pop      = res_pop_i && !res_empty_o;
  assign res_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (emit) mem_q[wptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (emit) wptr_q <= !wptr_q;
      if (do_pop) rptr_q <= !rptr_q;
      count_q <= count_q + {1'b0, emit} - {1'b0, do_pop};
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("output queue overfilled");

  a_fin_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res.finished |-> res.last) else $error("finished byte not last of item");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && fin |=> len_q == '0 && nov_q) else $error("length not cleared after message");

  a_no_store_counting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res.stored |-> !count_only_i) else $error("byte stored in count-only mode");

  a_pop_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> done_q == '0 && idx_q == 5'd0) else $error("walk state kept after item");

endmodule

`default_nettype wire

@@ sv/json_chat_message_encoder_unit.sv @@
// top level of the two-message chat encoder with string escaping
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------------
//  input    | in        | push / full      | mode_i, data_byte_i
//  result   | out       | pop / empty      | out_byte_o, position_o, stored_o, last_o,
//           |           |                  | finished_o, success_o, total_length_o
//  config   | in        | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// one result byte leaves per cycle while the output queue has room; an item yields
// 1 byte if plain, 2 or 6 for an escape, and up to 64 when fixed texts lead.
// these bytes are made by the single byte emitter in the back end, one item at a time.
// a new item is taken every cycle while the two-entry item queue has room.
// results wait in a two-entry output queue; once it is full, a stalled pop stops the emitter.
// reset clears phase, length, overflow flag and both configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module json_chat_message_encoder_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      position_o,
  output logic             stored_o,
  output logic             last_o,
  output logic             finished_o,
  output logic             success_o,
  output logic [15:0]      total_length_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0]    capacity_q;
  logic           count_only_q;
  logic           cmd_push, cmd_full, cmd_pop, cmd_valid;
  jcme_pkg::cmd_t cmd_in, cmd_head;
  jcme_pkg::res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= 16'd0;
      count_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jcme_pkg::CFG_CAPACITY:   capacity_q   <= cfg_data_i;
        jcme_pkg::CFG_COUNT_ONLY: count_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item intake and classification
  jcme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // decoupling queue
  jcme_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  // byte emitter
  jcme_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .count_only_i (count_only_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .res_empty_o  (empty),
    .res_pop_i    (pop),
    .res_o        (res)
  );

  // result fields
  assign out_byte_o     = res.out_byte;
  assign position_o     = res.position;
  assign stored_o       = res.stored;
  assign last_o         = res.last;
  assign finished_o     = res.finished;
  assign success_o      = res.success;
  assign total_length_o = res.total_length;

endmodule

`default_nettype wire

@@ test/json_chat_message_encoder_unit_tb.sv @@
// self-checking testbench of the two-message chat encoder with string escaping
`timescale 1ns / 1ps

module json_chat_message_encoder_unit_tb;

  // unused mode, the block ignores it
  localparam logic [1:0] MODE_IDLE = 2'd3;
  // length of all fixed texts and quotes of one message
  localparam int unsigned FIXED_TEXT_LEN = 61;
  localparam int unsigned LEN_MAX = 65535;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 425;
  localparam int unsigned CALM_FROM = 360;

  // one encoded byte as it leaves the block
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] position;
    logic        stored;
    logic        last;
    logic        finished;
    logic        success;
    logic [15:0] total_length;
  } enc_byte_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {AT_START, IN_SYSTEM, IN_USER} msg_phase_e;
  typedef enum logic [1:0] {ROW_ITEM, ROW_CAP, ROW_CNT} row_kind_e;

  // directed row: an item or a register write, with optional typed outcome
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  mode;
    logic [7:0]  data;
    logic [15:0] value;
    bit          chk;
    logic [15:0] total;
    bit          ok;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode_i = jcme_pkg::MODE_SYS;
  logic [7:0]  data_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic [15:0] position_o;
  logic        stored_o;
  logic        last_o;
  logic        finished_o;
  logic        success_o;
  logic [15:0] total_length_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = jcme_pkg::CFG_CAPACITY;
  logic [15:0] cfg_data_i = 16'h0000;

  // encoder image: registers and message state
  logic [15:0] m_capacity = 16'h0000;
  logic        m_count_only = 1'b0;
  msg_phase_e  m_phase = AT_START;
  int unsigned m_length = 0;
  logic        m_no_ovf = 1'b1;

  enc_byte_t   encoded_q[$];
  logic [7:0]  chunk_q[$];
  dir_row_t    dir_tab[$];
  int unsigned items_sent = 0;
  int unsigned rand_base = 0;
  int unsigned errors = 0;
  bit          quiet = 1'b0;
  int          pop_hold = 0;
  int unsigned stall_cycles = 0;

  json_chat_message_encoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .position_o     (position_o),
    .stored_o       (stored_o),
    .last_o         (last_o),
    .finished_o     (finished_o),
    .success_o      (success_o),
    .total_length_o (total_length_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
  endfunction

  // encoded size of one content byte
  function automatic int unsigned esc_len(input logic [7:0] c);
    case (c)
      8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09: return 2;
      default: return (c < 8'h20) ? 6 : 1;
    endcase
  endfunction

  // place the bytes of chunk_q as one chunk, whole or not at all
  task automatic add_chunk();
    int unsigned start;
    int unsigned n;
    int unsigned cap;
    logic fits;
    enc_byte_t r;
    start = m_length;
    n = chunk_q.size();
    cap = m_capacity;
    fits = 1'b0;
    if (m_count_only) begin
      m_length = (start + n > LEN_MAX) ? LEN_MAX : start + n;
    end else if (start > cap || n > cap - start || start + n > LEN_MAX) begin
      m_no_ovf = 1'b0;
    end else begin
      fits = 1'b1;
      m_length = start + n;
    end
    foreach (chunk_q[i]) begin
      r = '0;
      r.out_byte = chunk_q[i];
      r.position = fits ? 16'(start + i) : 16'h0000;
      r.stored = fits;
      r.total_length = 16'(m_length);
      encoded_q.push_back(r);
    end
  endtask

  task automatic add_text(input string s);
    chunk_q.delete();
    for (int i = 0; i < s.len(); i++) chunk_q.push_back(s[i]);
    add_chunk();
  endtask

  // json string escape of one content byte
  task automatic add_content(input logic [7:0] c);
    logic [7:0] letter;
    chunk_q.delete();
    letter = 8'h00;
    case (c)
      8'h22, 8'h5c: letter = c;
      8'h08: letter = "b";
      8'h0c: letter = "f";
      8'h0a: letter = "n";
      8'h0d: letter = "r";
      8'h09: letter = "t";
      default: ;
    endcase
    if (letter != 8'h00) begin
      chunk_q.push_back("\\");
      chunk_q.push_back(letter);
    end else if (c < 8'h20) begin
      chunk_q.push_back("\\");
      chunk_q.push_back("u");
      chunk_q.push_back("0");
      chunk_q.push_back("0");
      chunk_q.push_back(hex_char(c[7:4]));
      chunk_q.push_back(hex_char(c[3:0]));
    end else begin
      chunk_q.push_back(c);
    end
    add_chunk();
  endtask

  // emit the texts between the current phase and target
  task automatic advance(input msg_phase_e target);
    if (m_phase == AT_START) begin
      add_text("[{\"role\":\"system\",\"content\":");
      add_text("\"");
      m_phase = IN_SYSTEM;
    end
    if (m_phase == IN_SYSTEM && target == IN_USER) begin
      add_text("\"");
      add_text("},{\"role\":\"user\",\"content\":");
      add_text("\"");
      m_phase = IN_USER;
    end
  endtask

  // expected bytes of one accepted item
  task automatic predict_item(input logic [1:0] md, input logic [7:0] db);
    int unsigned first;
    logic fin;
    logic ok;
    enc_byte_t r;
    first = encoded_q.size();
    fin = 1'b0;
    ok = 1'b0;
    case (md)
      jcme_pkg::MODE_SYS: begin
        // system byte after user content lands in the user string
        advance((m_phase == IN_USER) ? IN_USER : IN_SYSTEM);
        add_content(db);
      end
      jcme_pkg::MODE_USR: begin
        advance(IN_USER);
        add_content(db);
      end
      jcme_pkg::MODE_END: begin
        advance(IN_USER);
        add_text("\"");
        add_text("}]");
        fin = 1'b1;
        ok = m_no_ovf && (m_count_only || m_length == m_capacity);
        m_phase = AT_START;
        m_length = 0;
        m_no_ovf = 1'b1;
      end
      default: ;
    endcase
    if (encoded_q.size() > first) begin
      r = encoded_q.pop_back();
      r.last = 1'b1;
      r.finished = fin;
      r.success = ok;
      encoded_q.push_back(r);
    end
  endtask

  // offer one item, with an occasional gap first, until it is taken
  task automatic send_item(input logic [1:0] md, input logic [7:0] db);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    mode_i <= md;
    data_byte_i <= db;
    do @(posedge clk_i); while (full);
    predict_item(md, db);
    if (md != MODE_IDLE) items_sent++;
  endtask

  // hold the sender until all expected bytes are out, then settle
  task automatic wait_idle(input int settle);
    do begin
      @(negedge clk_i);
      push <= 1'b0;
    end while (encoded_q.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] value);
    wait_idle(8);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == jcme_pkg::CFG_CAPACITY) m_capacity = value;
    else m_count_only = value[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(input row_kind_e k, input logic [1:0] md,
                                      input logic [7:0] db, input logic [15:0] v,
                                      input bit chk, input logic [15:0] tl, input bit ok);
    dir_row_t r;
    r.kind = k;
    r.mode = md;
    r.data = db;
    r.value = v;
    r.chk = chk;
    r.total = tl;
    r.ok = ok;
    return r;
  endfunction

  // content byte: escapes, controls and plain bytes
  function automatic logic [7:0] pick_content();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 6))
          0: return 8'h22;
          1: return 8'h5c;
          2: return 8'h08;
          3: return 8'h0c;
          4: return 8'h0a;
          5: return 8'h0d;
          default: return 8'h09;
        endcase
      end
      1: return 8'($urandom_range(0, 31));
      default: return 8'($urandom);
    endcase
  endfunction

  // one setting of the registers followed by a few messages
  task automatic run_random_phase();
    item_t plan[$];
    int n_msg;
    int form;
    int n_items;
    int split;
    int msg_len;
    int first_len;
    logic [1:0] md;
    logic [7:0] db;
    logic [15:0] cap;
    n_msg = $urandom_range(1, 3);
    first_len = -1;
    for (int m = 0; m < n_msg; m++) begin
      form = $urandom_range(0, 7);
      n_items = (form == 6) ? 0 : $urandom_range(0, 12);
      split = (form == 5) ? 0 : $urandom_range(0, n_items);
      msg_len = FIXED_TEXT_LEN;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 11) == 0) plan.push_back(item_t'{MODE_IDLE, 8'($urandom)});
        if (form == 7) begin
          md = ($urandom_range(0, 1) == 0) ? jcme_pkg::MODE_SYS : jcme_pkg::MODE_USR;
        end else begin
          md = (k < split) ? jcme_pkg::MODE_SYS : jcme_pkg::MODE_USR;
        end
        db = pick_content();
        msg_len += esc_len(db);
        plan.push_back(item_t'{md, db});
      end
      // sometimes the phase ends inside a message
      if (!(m == n_msg - 1 && $urandom_range(0, 5) == 0))
        plan.push_back(item_t'{jcme_pkg::MODE_END, 8'($urandom)});
      if (first_len < 0) first_len = msg_len;
    end
    case ($urandom_range(0, 5))
      0, 1: cap = 16'(first_len);
      2: cap = 16'(first_len - $urandom_range(1, 8));
      3: cap = 16'($urandom_range(0, 200));
      4: cap = 16'hffff;
      default: cap = 16'h0000;
    endcase
    cfg_write(jcme_pkg::CFG_CAPACITY, cap);
    cfg_write(jcme_pkg::CFG_COUNT_ONLY, {15'($urandom), ($urandom_range(0, 3) == 0)});
    quiet = (items_sent - rand_base >= CALM_FROM) || ($urandom_range(0, 3) == 0);
    foreach (plan[i]) begin
      if (!quiet && $urandom_range(0, 29) == 0) wait_idle(0);
      send_item(plan[i].mode, plan[i].data);
    end
  endtask

  // receiver with random stall bursts
  always @(negedge clk_i) begin
    if (!quiet && pop_hold == 0 && $urandom_range(0, 15) == 0) pop_hold = $urandom_range(1, 19);
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // compare each popped byte with the oldest expected one
  always @(posedge clk_i) begin : check_results
    enc_byte_t got;
    enc_byte_t want;
    if (rst_ni && pop && !empty) begin
      got = {out_byte_o, position_o, stored_o, last_o, finished_o, success_o, total_length_o};
      if (encoded_q.size() == 0) begin
        report_error($sformatf("byte %h with nothing expected", out_byte_o));
      end else begin
        want = encoded_q.pop_front();
        if (got !== want)
          report_error($sformatf(
            "got %h/%0d/%b/%b/%b/%b/%0d want %h/%0d/%b/%b/%b/%b/%0d",
            got.out_byte, got.position, got.stored, got.last, got.finished, got.success,
            got.total_length, want.out_byte, want.position, want.stored, want.last,
            want.finished, want.success, want.total_length));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("json_chat_message_encoder_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    enc_byte_t r;
    // after reset the capacity is zero, so every chunk is dropped
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'h00, 16'h0, 1'b1, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_CNT, jcme_pkg::MODE_SYS, 8'h00, 16'd1, 1'b0, 16'd0, 1'b0));
    // empty message measured
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'hff, 16'h0, 1'b1, 16'd61, 1'b1));
    // user byte first, then a system byte after user content, then noise
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_USR, 8'h00, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h41, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, MODE_IDLE, 8'hff, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'h00, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_CNT, jcme_pkg::MODE_SYS, 8'h00, 16'd0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_CAP, jcme_pkg::MODE_SYS, 8'h00, 16'hffff, 1'b0, 16'd0, 1'b0));
    // every escape class and the byte extremes
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h22, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h5c, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h08, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h0c, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h0a, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h0d, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h09, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h1f, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h20, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h7f, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'hff, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_USR, 8'h00, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_USR, 8'h80, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'h00, 16'h0, 1'b0, 16'd0, 1'b0));
    // exact fill of an empty message
    dir_tab.push_back(mk_row(ROW_CAP, jcme_pkg::MODE_SYS, 8'h00, 16'd61, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'h00, 16'h0, 1'b1, 16'd61, 1'b1));
    // capacity lowered below the length mid-message
    dir_tab.push_back(mk_row(ROW_CAP, jcme_pkg::MODE_SYS, 8'h00, 16'd40, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_SYS, 8'h61, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_CAP, jcme_pkg::MODE_SYS, 8'h00, 16'd10, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_USR, 8'h62, 16'h0, 1'b0, 16'd0, 1'b0));
    dir_tab.push_back(mk_row(ROW_ITEM, jcme_pkg::MODE_END, 8'h00, 16'h0, 1'b1, 16'd30, 1'b0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CAP: cfg_write(jcme_pkg::CFG_CAPACITY, dir_tab[i].value);
        ROW_CNT: cfg_write(jcme_pkg::CFG_COUNT_ONLY, {15'($urandom), dir_tab[i].value[0]});
        default: begin
          send_item(dir_tab[i].mode, dir_tab[i].data);
          if (dir_tab[i].chk) begin
            // the typed outcome governs the final byte of this item
            r = encoded_q.pop_back();
            if (r.total_length !== dir_tab[i].total || r.success !== dir_tab[i].ok)
              report_error($sformatf("row %0d: typed outcome differs from prediction", i));
            r.total_length = dir_tab[i].total;
            r.success = dir_tab[i].ok;
            encoded_q.push_back(r);
          end
        end
      endcase
    end

    // random messages under changing settings, calm at the end
    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) run_random_phase();

    quiet = 1'b1;
    wait_idle(16);
    if (errors == 0) $display("json_chat_message_encoder_unit_tb: PASS");
    else $display("json_chat_message_encoder_unit_tb: FAIL");
    $finish;
  end

endmodule
